@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Types and constants of the page region classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prc_pkg;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = 20;
  localparam int COUNT_W    = PAGE_W + 1;
  localparam int KIND_W     = 2;
  localparam int AUTH_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PAGE_W;

  localparam int MAX_REGIONS_DEF = 256;

  localparam logic [ADDR_W-1:0] USER_LO_ADDR = 32'h4000_0000;
  localparam logic [ADDR_W-1:0] USER_HI_ADDR = 32'hF000_0000;
  localparam logic [PAGE_W-1:0] USER_LOW_RESET  = USER_LO_ADDR[ADDR_W-1:PAGE_SHIFT];
  localparam logic [PAGE_W-1:0] USER_HIGH_RESET = USER_HI_ADDR[ADDR_W-1:PAGE_SHIFT];

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd2;

  // Authority codes
  localparam logic [AUTH_W-1:0] AUTH_NONE   = 2'd0;
  localparam logic [AUTH_W-1:0] AUTH_KERNEL = 2'd1;
  localparam logic [AUTH_W-1:0] AUTH_USER   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USER_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_HIGH = 1'd1;

  localparam logic [ADDR_W-1:0] TYPE_AVAILABLE = 32'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] rgn_start;
    logic [ADDR_W-1:0] rgn_end;
    logic              avail;
  } prc_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } prc_state_t;

endpackage

@@ hw/rtl/page_region_classifier.sv @@
// ----------------------------------------------------------------------------
// page_region_classifier
// Region table loaded in order and a sequential scanner that classifies pages.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. in_kind selects
//   clear, load or classify; the other in_ fields carry the region or page.
//   Every item gives exactly one result, shown for one cycle with out_valid.
//   The receiver cannot stall, so results are never held.
//   Clear, load, unknown kinds and classify of a page outside the user range
//   (or with an empty table) produce their result in the next cycle and keep
//   busy low, so such items can come every cycle.
//   A user-range classify walks the region table one entry per cycle through
//   a single registered read port and one shared range comparator: it first
//   fetches entry zero, then examines the entries in order until the first hit
//   or the last loaded entry; at most MAX_REGIONS entries are examined. Busy
//   is high through the fetch and the scan.
//   cfg_we writes the user page bounds; write them only while idle.
//   Reset empties the table (the count goes to zero; the memory itself is not
//   cleared, since only loaded entries are read) and restores the bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_region_classifier #(
  parameter int MAX_REGIONS = prc_pkg::MAX_REGIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [prc_pkg::KIND_W-1:0]          in_kind,
  input  logic [prc_pkg::ADDR_W-1:0]          in_region_start,
  input  logic [prc_pkg::ADDR_W-1:0]          in_region_end,
  input  logic [prc_pkg::ADDR_W-1:0]          in_region_type,
  input  logic [prc_pkg::PAGE_W-1:0]          in_page_index,
  output logic                                out_valid,
  output logic [prc_pkg::AUTH_W-1:0]          out_authority,
  output logic [prc_pkg::COUNT_W-1:0]         out_page_count,
  output logic                                out_beyond_count,
  output logic                                out_table_full,
  input  logic                                cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import prc_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  prc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0] pages_r, pages_nxt;
  logic [PAGE_W-1:0]  user_low_r, user_high_r;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [AUTH_W-1:0]  out_auth_r, out_auth_nxt;
  logic [COUNT_W-1:0] out_pages_r, out_pages_nxt;
  logic               out_beyond_r, out_beyond_nxt;
  logic               out_full_r, out_full_nxt;

  prc_entry_t         mem [MAX_REGIONS];
  prc_entry_t         rdata_r;
  prc_entry_t         wr_entry;
  logic               mem_we;
  logic [IDX_W-1:0]   rd_addr;

  logic               accept;
  logic               in_kernel;
  logic               table_has_room;
  logic               hit;
  logic               last_entry;
  logic [ADDR_W-1:0]  page_first;
  logic [ADDR_W-1:0]  page_last;

  assign busy           = (state_r != ST_IDLE);
  assign accept         = start && !busy;
  assign in_kernel      = (in_page_index < user_low_r) || (in_page_index > user_high_r);
  assign table_has_room = (count_r < CNT_W'(MAX_REGIONS));

  // Shared range comparator: does the current table entry fully hold the page?
  assign page_first = {page_r, {PAGE_SHIFT{1'b0}}};
  assign page_last  = {page_r, {PAGE_SHIFT{1'b1}}};
  assign hit        = (page_first >= rdata_r.rgn_start) && (page_last < rdata_r.rgn_end);
  assign last_entry = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign rd_addr = (state_r == ST_SCAN) ? (idx_r + IDX_W'(1)) : '0;

  assign wr_entry.rgn_start = in_region_start;
  assign wr_entry.rgn_end   = in_region_end;
  assign wr_entry.avail     = (in_region_type == TYPE_AVAILABLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_CLASSIFY) && !in_kernel && (count_r != '0)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (hit || last_entry) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    count_nxt      = count_r;
    pages_nxt      = pages_r;
    page_nxt       = page_r;
    idx_nxt        = idx_r;
    mem_we         = 1'b0;
    out_valid_nxt  = 1'b0;
    out_auth_nxt   = AUTH_NONE;
    out_pages_nxt  = pages_r;
    out_beyond_nxt = 1'b0;
    out_full_nxt   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          page_nxt = in_page_index;
          idx_nxt  = '0;
          case (in_kind)
            KIND_CLEAR: begin
              count_nxt     = '0;
              pages_nxt     = '0;
              out_pages_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            KIND_LOAD: begin
              out_valid_nxt = 1'b1;
              if (table_has_room) begin
                mem_we        = 1'b1;
                count_nxt     = count_r + CNT_W'(1);
                pages_nxt     = COUNT_W'(in_region_end[ADDR_W-1:PAGE_SHIFT]) + COUNT_W'(1);
                out_pages_nxt = pages_nxt;
              end else begin
                out_full_nxt = 1'b1;
              end
            end
            KIND_CLASSIFY: begin
              out_beyond_nxt = ({1'b0, in_page_index} >= pages_r);
              if (in_kernel) begin
                out_auth_nxt  = AUTH_KERNEL;
                out_valid_nxt = 1'b1;
              end else if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_FETCH: ;
      ST_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (hit || last_entry) begin
          out_valid_nxt  = 1'b1;
          out_beyond_nxt = ({1'b0, page_r} >= pages_r);
          if (hit && rdata_r.avail) begin
            out_auth_nxt = AUTH_USER;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pages_r     <= '0;
      out_valid_r <= 1'b0;
      user_low_r  <= USER_LOW_RESET;
      user_high_r <= USER_HIGH_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pages_r     <= pages_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_USER_LOW:  user_low_r  <= cfg_wdata;
          REG_USER_HIGH: user_high_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    idx_r        <= idx_nxt;
    out_auth_r   <= out_auth_nxt;
    out_pages_r  <= out_pages_nxt;
    out_beyond_r <= out_beyond_nxt;
    out_full_r   <= out_full_nxt;
  end

  // Region table: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_authority    = out_auth_r;
  assign out_page_count   = out_pages_r;
  assign out_beyond_count = out_beyond_r;
  assign out_table_full   = out_full_r;

  `PRC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_REGIONS))
  `PRC_ASSERT_NOW(a_scan_in_table, state_r == ST_SCAN, CNT_W'(idx_r) < count_r)
  `PRC_ASSERT_NOW(a_full_no_auth, out_valid_r && out_table_full, out_authority == AUTH_NONE)
  `PRC_ASSERT_NEXT(a_full_drop,
    accept && (in_kind == KIND_LOAD) && !table_has_room,
    out_valid && out_table_full && (count_r == CNT_W'(MAX_REGIONS)))

endmodule
